[rtl/fcs_pkg.sv]
// ----------------------------------------------------------------------------
// fcs_pkg
// Types and constants shared by the frame checksum serializer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcs_pkg;

	// frame kind carried on the input tuser
	typedef enum logic [1:0] {
		CMD_IMU  = 2'd0,
		CMD_ACC  = 2'd1,
		CMD_USER = 2'd2,
		CMD_NONE = 2'd3
	} fcs_cmd_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMU_ID    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_USER_ID   = 8'd3;

	localparam logic [7:0] HEAD_RST    = 8'd170;
	localparam logic [7:0] DEST_RST    = 8'd255;
	localparam logic [7:0] IMU_ID_RST  = 8'd1;
	localparam logic [7:0] USER_ID_RST = 8'd241;

	localparam int unsigned HDR_BYTES  = 4;
	localparam logic [7:0]  IMU_LEN    = 8'd13;
	localparam logic [7:0]  USER_LEN   = 8'd12;

	// header plus payload, the bytes that pass through the shift register
	localparam int unsigned SHREG_BYTES = 17;
	localparam int unsigned SHREG_W     = SHREG_BYTES * 8;
	localparam logic [4:0]  IMU_BYTES   = 5'd17;
	localparam logic [4:0]  USER_BYTES  = 5'd16;

	// checksum unit control
	typedef struct packed {
		logic clear;
		logic add;
	} fcs_ctl_t;

endpackage

`default_nettype wire

[rtl/imu_frame_checksum_serializer.sv]
// ----------------------------------------------------------------------------
// imu_frame_checksum_serializer
// The first frame byte reaches m_tdata through the state and output registers
// after the input transfer. Output is one byte per cycle, while m_tready allows,
// from a shift register that moves a byte at a time; input is taken only when
// idle, so no new sample set is taken until the frame is serialized. IMU and
// accel frames carry 19 bytes, user frames 18. Kind 3 is taken and dropped.
// Reset: registers return to their defaults, no frame pending, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_frame_checksum_serializer
	import fcs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	// sample input
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// acc_x[31:0], acc_y[63:32], acc_z[95:64], gyr_x[111:96], gyr_y[127:112],
	// gyr_z[143:128], shock_flag[151:144]
	input  wire logic [151:0]         s_tdata,
	input  wire logic [1:0]           s_tuser,  // command
	// frame byte output
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,  // frame_byte
	output logic                      m_tlast   // last_byte
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DATA,
		ST_SUM,
		ST_ADD
	} state_t;

	state_t state_q;
	logic [4:0] cnt_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;

	logic [7:0] head_q;
	logic [7:0] dest_q;
	logic [7:0] imu_id_q;
	logic [7:0] user_id_q;

	logic [SHREG_W-1:0] shreg_q;
	logic [SHREG_W-1:0] load_vec;
	logic [4:0]         load_cnt;

	logic       s_xfer;
	logic       adv;
	logic       emit;
	fcs_cmd_t   cmd;
	fcs_ctl_t   chk_ctl;
	logic [7:0] sum_check;
	logic [7:0] add_check;

	assign cmd       = fcs_cmd_t'(s_tuser);
	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	// output register free or being emptied this cycle
	assign adv       = !m_tvalid_q || m_tready;
	// a frame byte enters the output register
	assign emit      = (state_q != ST_IDLE) && adv;

	// frame image: header bytes first, payload little-endian after
	always_comb begin
		load_vec = '0;
		load_cnt = IMU_BYTES;
		load_vec[8*HDR_BYTES-1:0] = {8'd0, imu_id_q, dest_q, head_q};
		case (cmd)
			CMD_IMU: begin
				load_vec[31:24]   = IMU_LEN;
				load_vec[135:32]  = {s_tdata[151:96], s_tdata[79:64],
					s_tdata[47:32], s_tdata[15:0]};
			end
			CMD_ACC: begin
				load_vec[31:24]   = IMU_LEN;
				load_vec[79:32]   = {s_tdata[79:64], s_tdata[47:32], s_tdata[15:0]};
			end
			CMD_USER: begin
				load_vec[23:16]   = user_id_q;
				load_vec[31:24]   = USER_LEN;
				load_vec[127:32]  = s_tdata[95:0];
				load_cnt          = USER_BYTES;
			end
			default: begin
				load_cnt = IMU_BYTES;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			shreg_q <= load_vec;
		end else if (state_q == ST_DATA && adv) begin
			shreg_q <= {8'd0, shreg_q[SHREG_W-1:8]};
		end
	end

	assign chk_ctl.clear = s_xfer;
	assign chk_ctl.add   = (state_q == ST_DATA) && adv;

	fcs_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (chk_ctl),
		.byte_in   (shreg_q[7:0]),
		.sum_check (sum_check),
		.add_check (add_check)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= 5'd0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= 8'd0;
			m_tlast_q  <= 1'b0;
			head_q     <= HEAD_RST;
			dest_q     <= DEST_RST;
			imu_id_q   <= IMU_ID_RST;
			user_id_q  <= USER_ID_RST;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_HEAD:    head_q    <= cfg_data;
					CFG_DEST:    dest_q    <= cfg_data;
					CFG_IMU_ID:  imu_id_q  <= cfg_data;
					CFG_USER_ID: user_id_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_xfer && cmd != CMD_NONE) begin
						state_q <= ST_DATA;
						cnt_q   <= load_cnt;
					end
				end
				ST_DATA: begin
					if (adv) begin
						m_tdata_q  <= shreg_q[7:0];
						m_tlast_q  <= 1'b0;
						cnt_q      <= cnt_q - 5'd1;
						if (cnt_q == 5'd1) begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (adv) begin
						m_tdata_q  <= sum_check;
						m_tlast_q  <= 1'b0;
						state_q    <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (adv) begin
						m_tdata_q  <= add_check;
						m_tlast_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef NO_ASSERTIONS
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && cmd != CMD_NONE |=> state_q == ST_DATA && cnt_q >= USER_BYTES)
		else $error("frame did not start after input transfer");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && cmd == CMD_NONE |=> state_q == ST_IDLE)
		else $error("kind 3 started a frame");
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DATA |-> cnt_q != 5'd0)
		else $error("byte count ran out inside payload");
	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |-> !(m_tvalid_q && m_tlast_q))
		else $error("last byte shown before add-check");
`endif

endmodule

`default_nettype wire

[rtl/fcs_check.sv]
// ----------------------------------------------------------------------------
// fcs_check
// Sum-check and add-check accumulators, one byte per cycle while ctl.add is set.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_check
	import fcs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire fcs_ctl_t ctl,
	input  wire logic [7:0] byte_in,
	output logic [7:0]    sum_check,
	output logic [7:0]    add_check
);

	logic [7:0] sum_q;
	logic [7:0] add_q;
	logic [7:0] sum_next;

	assign sum_next = sum_q + byte_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 8'd0;
			add_q <= 8'd0;
		end else if (ctl.clear) begin
			sum_q <= 8'd0;
			add_q <= 8'd0;
		end else if (ctl.add) begin
			sum_q <= sum_next;
			// add-check sums the running sum taken after each byte
			add_q <= add_q + sum_next;
		end
	end

	assign sum_check = sum_q;
	assign add_check = add_q;

`ifndef NO_ASSERTIONS
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (sum_q == 8'd0) && (add_q == 8'd0))
		else $error("checksum not cleared at frame start");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.clear && !ctl.add |=> $stable(sum_q) && $stable(add_q))
		else $error("checksum moved without a byte");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_imu_frame_checksum_serializer.sv]
// ----------------------------------------------------------------------------
// tb_imu_frame_checksum_serializer
// Streams sample sets of all three frame kinds through the serializer with
// random gaps on both sides. A scoreboard builds each expected frame (header,
// payload, sum-check, add-check) and compares every output byte in order.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------

module tb_imu_frame_checksum_serializer
	import fcs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int SETTLE_CYCLES   = 10;
	localparam int ITEMS_PER_PHASE = 60;

	// indexes past the register file, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 8'hFF;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	class frame_scoreboard;
		logic [7:0]  head;
		logic [7:0]  dest;
		logic [7:0]  imu_id;
		logic [7:0]  user_id;
		frame_byte_t bytes_due[$];

		function new();
			head    = HEAD_RST;
			dest    = DEST_RST;
			imu_id  = IMU_ID_RST;
			user_id = USER_ID_RST;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			case (idx)
				CFG_HEAD:    head = val;
				CFG_DEST:    dest = val;
				CFG_IMU_ID:  imu_id = val;
				CFG_USER_ID: user_id = val;
				default: ;
			endcase
		endfunction

		// builds the full frame for one accepted sample set
		function void add_sample(fcs_cmd_t cmd, logic [151:0] smp);
			logic [7:0]  body[$];
			logic [7:0]  csum;
			logic [7:0]  acsum;
			frame_byte_t fb;
			if (cmd == CMD_NONE)
				return;
			body.push_back(head);
			body.push_back(dest);
			if (cmd == CMD_USER) begin
				body.push_back(user_id);
				body.push_back(USER_LEN);
				for (int k = 0; k < 12; k++)
					body.push_back(smp[8*k +: 8]);
			end else begin
				body.push_back(imu_id);
				body.push_back(IMU_LEN);
				// low half of each accel word only
				for (int a = 0; a < 3; a++) begin
					body.push_back(smp[32*a +: 8]);
					body.push_back(smp[32*a+8 +: 8]);
				end
				// gyro words and shock byte sit contiguously from bit 96
				for (int k = 0; k < 7; k++)
					body.push_back((cmd == CMD_IMU) ? smp[96+8*k +: 8] : 8'h00);
			end
			csum  = 8'h00;
			acsum = 8'h00;
			foreach (body[i]) begin
				csum    = csum + body[i];
				acsum   = acsum + csum;
				fb.data = body[i];
				fb.last = 1'b0;
				bytes_due.push_back(fb);
			end
			fb.data = csum;
			fb.last = 1'b0;
			bytes_due.push_back(fb);
			fb.data = acsum;
			fb.last = 1'b1;
			bytes_due.push_back(fb);
		endfunction

		// empty string when the byte matches the oldest expectation
		function string check_byte(logic [7:0] got, logic got_last);
			frame_byte_t want;
			string       msg;
			if (bytes_due.size() == 0)
				return $sformatf("unexpected byte %02h (last %b)", got, got_last);
			want = bytes_due.pop_front();
			msg  = "";
			if (got !== want.data)
				msg = $sformatf("byte %02h, expected %02h", got, want.data);
			if (got_last !== want.last) begin
				if (msg != "")
					msg = {msg, "; "};
				msg = {msg, $sformatf("last %b, expected %b", got_last, want.last)};
			end
			return msg;
		endfunction

		function int outstanding();
			return bytes_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [151:0]         s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;
	logic                 m_tlast;

	frame_scoreboard sb;
	int              mismatches;
	int              quiet_cycles;
	bit              tx_fast;
	bit              rx_fast;

	imu_frame_checksum_serializer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic logic [151:0] pack_sample(
		logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
		logic [15:0] gx, logic [15:0] gy, logic [15:0] gz, logic [7:0] shock);
		return {shock, gz, gy, gx, az, ay, ax};
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'hFFFF_7FFF;
			5: return 32'h0000_8000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [15:0] pick_half();
		logic [31:0] w;
		w = pick_word();
		return w[15:0];
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [31:0] w;
		w = pick_word();
		return w[7:0];
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input fcs_cmd_t cmd, input logic [151:0] smp);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		sb.add_sample(cmd, smp);
	endtask

	task automatic send_random(output bit counted);
		fcs_cmd_t cmd;
		case ($urandom_range(0, 9))
			0, 1, 2: cmd = CMD_IMU;
			3, 4, 5: cmd = CMD_ACC;
			6, 7, 8: cmd = CMD_USER;
			default: cmd = CMD_NONE;
		endcase
		counted = (cmd != CMD_NONE);
		send_sample(cmd, pack_sample(pick_word(), pick_word(), pick_word(),
			pick_half(), pick_half(), pick_half(), pick_byte()));
	endtask

	// stop sending, wait for every expected byte, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// output ready with a fresh stall before each transfer
	initial begin : rx_drive
		int stall;
		@(posedge arst_n);
		forever begin
			stall = rx_fast ? 0 : $urandom_range(0, 4);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : check_out
		string msg;
		if (arst_n && m_tvalid && m_tready) begin
			msg = sb.check_byte(m_tdata, m_tlast);
			if (msg != "")
				report(msg);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		bit counted;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = CMD_NONE;
		m_tready     = 1'b0;
		tx_fast      = 1'b0;
		rx_fast      = 1'b0;
		mismatches   = 0;
		sb           = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames with the reset register values
		send_sample(CMD_NONE, pack_sample($urandom(), $urandom(), $urandom(),
			16'h1234, 16'h5678, 16'h9ABC, 8'h3C));
		send_sample(CMD_IMU, '0);
		send_sample(CMD_IMU, '1);
		send_sample(CMD_IMU, pack_sample(32'h0000_7FFF, 32'h0000_8000, 32'h0000_0001,
			16'h7FFF, 16'h8000, 16'hFFFF, 8'h01));
		// upper accel halves must not leak into the frame
		send_sample(CMD_IMU, pack_sample(32'h1234_5678, 32'hFFFF_0000, 32'h8000_7FFF,
			16'h0001, 16'hFFFE, 16'h8001, 8'h80));
		send_sample(CMD_ACC, '0);
		send_sample(CMD_ACC, '1);
		send_sample(CMD_ACC, pack_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_8000,
			16'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom())));
		send_sample(CMD_NONE, '1);
		send_sample(CMD_USER, '0);
		send_sample(CMD_USER, '1);
		send_sample(CMD_USER, pack_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_sample(CMD_USER, pack_sample($urandom(), $urandom(), $urandom(),
			16'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom())));
		// back to back, no idling on either side
		tx_fast = 1'b1;
		rx_fast = 1'b1;
		send_sample(CMD_NONE, pack_sample($urandom(), $urandom(), $urandom(),
			16'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom())));
		send_sample(CMD_IMU, pack_sample($urandom(), $urandom(), $urandom(),
			16'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom())));
		send_sample(CMD_USER, pack_sample($urandom(), $urandom(), $urandom(),
			16'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom())));
		send_sample(CMD_ACC, pack_sample($urandom(), $urandom(), $urandom(),
			16'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom())));
		send_sample(CMD_IMU, pack_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		tx_fast = 1'b0;
		rx_fast = 1'b0;
		drain();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					write_reg(CFG_HEAD, 8'h00);
					write_reg(CFG_DEST, 8'h00);
					write_reg(CFG_IMU_ID, 8'h00);
					write_reg(CFG_USER_ID, 8'h00);
					write_reg(CFG_SPARE, 8'h5A);
					write_reg(CFG_TOP, 8'hFF);
				end
				1: begin
					write_reg(CFG_HEAD, 8'hFF);
					write_reg(CFG_DEST, 8'hFF);
					write_reg(CFG_IMU_ID, 8'hFF);
					write_reg(CFG_USER_ID, 8'hFF);
				end
				default: begin
					write_reg(CFG_USER_ID, 8'($urandom_range(0, 255)));
					write_reg(CFG_IMU_ID, 8'($urandom_range(0, 255)));
					write_reg(CFG_DEST, 8'($urandom_range(0, 255)));
					write_reg(CFG_HEAD, 8'($urandom_range(0, 255)));
				end
			endcase
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				if (n % 16 == 0) begin
					tx_fast = ($urandom_range(0, 3) == 0);
					rx_fast = ($urandom_range(0, 3) == 0);
				end
				send_random(counted);
				if (counted)
					n++;
				if ($urandom_range(0, 49) == 0)
					drain();
			end
			tx_fast = 1'b0;
			rx_fast = 1'b0;
			drain();
		end

		if (sb.outstanding() != 0)
			report($sformatf("%0d expected bytes never arrived", sb.outstanding()));
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
